FILE: hdl/scf_pkg.sv
// Package for the serial command frame parser.
// Holds character codes, keyword lengths, light modes and the keyword table.
// No dependencies.
`timescale 1ns / 1ps

package scf_pkg;

  localparam int LINE_BYTES_DEF = 32;

  localparam logic [7:0] CH_START = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_NORMAL  = 2'd1;
  localparam logic [1:0] MODE_WARNING = 2'd2;
  localparam logic [1:0] MODE_ERROR   = 2'd3;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic [2:0] LEN_OFF     = 3'd3;
  localparam logic [2:0] LEN_NORMAL  = 3'd6;
  localparam logic [2:0] LEN_WARNING = 3'd7;
  localparam logic [2:0] LEN_ERROR   = 3'd5;

  // Result of one keyword compare, handed from the compare sequencer to the top.
  typedef struct packed {
    logic       valid;
    logic       status;
    logic [1:0] mode;
  } judge_res_t;

  // Character of a keyword at a position; positions past the keyword read as zero.
  function automatic logic [7:0] keyword_char(input logic [1:0] mode, input logic [2:0] pos);
    logic [7:0] ch;
    ch = CH_NUL;
    case (mode)
      MODE_OFF: begin
        case (pos)
          3'd0: ch = "o";
          3'd1: ch = "f";
          3'd2: ch = "f";
          default: ch = CH_NUL;
        endcase
      end
      MODE_NORMAL: begin
        case (pos)
          3'd0: ch = "n";
          3'd1: ch = "o";
          3'd2: ch = "r";
          3'd3: ch = "m";
          3'd4: ch = "a";
          3'd5: ch = "l";
          default: ch = CH_NUL;
        endcase
      end
      MODE_WARNING: begin
        case (pos)
          3'd0: ch = "w";
          3'd1: ch = "a";
          3'd2: ch = "r";
          3'd3: ch = "n";
          3'd4: ch = "i";
          3'd5: ch = "n";
          3'd6: ch = "g";
          default: ch = CH_NUL;
        endcase
      end
      default: begin
        case (pos)
          3'd0: ch = "e";
          3'd1: ch = "r";
          3'd2: ch = "r";
          3'd3: ch = "o";
          3'd4: ch = "r";
          default: ch = CH_NUL;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] keyword_len(input logic [1:0] mode);
    logic [2:0] len;
    case (mode)
      MODE_OFF:     len = LEN_OFF;
      MODE_NORMAL:  len = LEN_NORMAL;
      MODE_WARNING: len = LEN_WARNING;
      default:      len = LEN_ERROR;
    endcase
    return len;
  endfunction

endpackage

FILE: hdl/scf_if.sv
// Channel interfaces of the serial command frame parser: received bytes in,
// command results out. Depends on nothing.
`timescale 1ns / 1ps

interface scf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface scf_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [1:0] light_mode;

  modport source (output valid, output status, output light_mode, input ready);
  modport sink (input valid, input status, input light_mode, output ready);
endinterface

FILE: hdl/serial_command_frame_parser.sv
// Serial command frame parser, top level.
// Every byte takes one cycle, except LF after CR: the input then stays not ready
// while the single compare sequencer walks the line, and until its result is taken
// into the output register.
// A result waits in an output register; while it is held, the compare sequencer stays in J_DONE.
// Synchronous active-low reset returns to hunting with an empty line.
`timescale 1ns / 1ps

module serial_command_frame_parser #(
  parameter int LINE_BYTES = scf_pkg::LINE_BYTES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  scf_in_if.sink    in_ch,
  scf_out_if.source out_ch
);
  import scf_pkg::*;

  localparam int AW = $clog2(LINE_BYTES);
  localparam int CW = $clog2(LINE_BYTES + 1);

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_COLLECT = 2'd1;
  localparam logic [1:0] PH_WAIT_LF = 2'd2;
  localparam logic [1:0] PH_JUDGE   = 2'd3;

  logic [1:0]    phase_r, phase_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          status_r, status_nxt;
  logic [1:0]    mode_r, mode_nxt;

  logic          accept;
  logic [7:0]    ch;
  logic          wr_en;
  logic          start;
  logic          take;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  judge_res_t    res;

  assign in_ch.ready = (phase_r != PH_JUDGE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign ch          = in_ch.rx_byte;

  assign take = res.valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    phase_nxt = phase_r;
    fill_nxt  = fill_r;
    wr_en     = 1'b0;
    start     = 1'b0;
    case (phase_r)
      PH_HUNT: begin
        if (accept && ch == CH_START) begin
          phase_nxt = PH_COLLECT;
        end
      end
      PH_COLLECT: begin
        if (accept) begin
          if (ch == CH_START) begin
            fill_nxt = '0;
          end else if (ch == CH_CR) begin
            phase_nxt = PH_WAIT_LF;
          end else if (fill_r < CW'(LINE_BYTES)) begin
            wr_en    = 1'b1;
            fill_nxt = fill_r + 1'b1;
          end else begin
            fill_nxt  = '0;
            phase_nxt = PH_HUNT;
          end
        end
      end
      PH_WAIT_LF: begin
        if (accept) begin
          if (ch == CH_LF) begin
            start     = 1'b1;
            phase_nxt = PH_JUDGE;
          end else begin
            fill_nxt  = '0;
            phase_nxt = PH_HUNT;
          end
        end
      end
      PH_JUDGE: begin
        if (take) begin
          fill_nxt  = '0;
          phase_nxt = PH_HUNT;
        end
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    mode_nxt      = mode_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (take) begin
      out_valid_nxt = 1'b1;
      status_nxt    = res.status;
      mode_nxt      = res.mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    mode_r   <= mode_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.light_mode = mode_r;

  scf_line_mem #(
    .LINE_BYTES(LINE_BYTES),
    .AW        (AW)
  ) u_line_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(fill_r[AW-1:0]),
    .wr_data(ch),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  scf_judge #(
    .LINE_BYTES(LINE_BYTES),
    .AW        (AW),
    .CW        (CW)
  ) u_judge (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .fill   (fill_r),
    .take   (take),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .res    (res)
  );

endmodule

FILE: hdl/scf_line_mem.sv
// Line store of the frame parser: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module scf_line_mem #(
  parameter int LINE_BYTES = 32,
  parameter int AW = $clog2(LINE_BYTES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [LINE_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/scf_judge.sv
// Keyword compare sequencer: walks the line store one byte at a time, reading and then
// comparing each, and checks the command word against the four keywords. Uses scf_pkg.
`timescale 1ns / 1ps

module scf_judge #(
  parameter int LINE_BYTES = 32,
  parameter int AW = $clog2(LINE_BYTES),
  parameter int CW = $clog2(LINE_BYTES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [CW-1:0]       fill,
  input  logic                take,
  output logic [AW-1:0]       rd_addr,
  input  logic [7:0]          rd_data,
  output scf_pkg::judge_res_t res
);
  import scf_pkg::*;

  localparam logic [1:0] J_IDLE = 2'd0;
  localparam logic [1:0] J_RD   = 2'd1;
  localparam logic [1:0] J_CMP  = 2'd2;
  localparam logic [1:0] J_DONE = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [3:0]    match_r, match_nxt;
  logic [3:0]    hit;
  logic          word_end;

  assign rd_addr  = idx_r[AW-1:0];
  assign word_end = (rd_data == CH_NUL) || (rd_data == CH_COMMA);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    fill_nxt  = fill_r;
    match_nxt = match_r;
    case (state_r)
      J_IDLE: begin
        if (start) begin
          state_nxt = J_RD;
          idx_nxt   = '0;
          fill_nxt  = fill;
          match_nxt = 4'b1111;
        end
      end
      J_RD: begin
        // The read for idx_r is issued in this cycle and seen in J_CMP.
        if (idx_r == fill_r) begin
          state_nxt = J_DONE;
        end else begin
          state_nxt = J_CMP;
        end
      end
      J_CMP: begin
        if (word_end) begin
          state_nxt = J_DONE;
        end else begin
          for (int k = 0; k < 4; k++) begin
            if (idx_r >= CW'(keyword_len(2'(k))) ||
                rd_data != keyword_char(2'(k), idx_r[2:0])) begin
              match_nxt[k] = 1'b0;
            end
          end
          idx_nxt   = idx_r + 1'b1;
          state_nxt = J_RD;
        end
      end
      J_DONE: begin
        if (take) begin
          state_nxt = J_IDLE;
        end
      end
      default: state_nxt = J_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= J_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    fill_r  <= fill_nxt;
    match_r <= match_nxt;
  end

  // A keyword hits when every position matched and the word has its exact length.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hit[k] = match_r[k] && (idx_r == CW'(keyword_len(2'(k))));
    end
  end

  always_comb begin
    res.valid  = (state_r == J_DONE);
    res.status = STATUS_ERR;
    res.mode   = MODE_OFF;
    if (hit[MODE_OFF]) begin
      res.status = STATUS_OK;
      res.mode   = MODE_OFF;
    end else if (hit[MODE_NORMAL]) begin
      res.status = STATUS_OK;
      res.mode   = MODE_NORMAL;
    end else if (hit[MODE_WARNING]) begin
      res.status = STATUS_OK;
      res.mode   = MODE_WARNING;
    end else if (hit[MODE_ERROR]) begin
      res.status = STATUS_OK;
      res.mode   = MODE_ERROR;
    end
  end

endmodule

FILE: bench/testbench.sv
// Self-checking bench for serial_command_frame_parser: drives byte traffic with
// bursts, gaps and receiver stalls, and scores results against a frame predictor.
// Depends on scf_pkg and the channel interfaces in scf_if.sv.
`timescale 1ns / 1ps

module testbench;
  import scf_pkg::*;

  localparam int LINE_LEN    = LINE_BYTES_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 2 * LINE_LEN + 40;
  localparam int LIVE_TARGET = 1200;

  typedef enum logic [1:0] {HUNTING, COLLECTING, AWAIT_LF} frame_phase_t;

  typedef struct packed {
    logic       status;
    logic [1:0] mode;
  } cmd_result_t;

  logic clk;
  logic rst_n;

  scf_in_if  in_ch ();
  scf_out_if out_ch ();

  serial_command_frame_parser #(.LINE_BYTES(LINE_LEN)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Frame tracker state, mirrors the parser.
  frame_phase_t frame_phase = HUNTING;
  logic [7:0]   line_buf [LINE_LEN];
  int           line_fill = 0;
  cmd_result_t  expected_replies [$];

  int mismatch_count = 0;
  int live_bytes     = 0;
  int burst_left     = 0;
  int idle_cycles    = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int sink_mode      = 0;
  int sink_left      = 0;

  string kw_names [4] = '{"off", "normal", "warning", "error"};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 100) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic bit word_equals(input int wlen, input logic [55:0] word_text,
                                     input int kw_len);
    if (wlen != kw_len) return 1'b0;
    for (int i = 0; i < kw_len; i++) begin
      if (line_buf[i] != word_text[8 * (kw_len - 1 - i) +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // The command word runs up to the first comma or zero byte.
  function automatic cmd_result_t judge_command();
    cmd_result_t r;
    int          wlen;
    wlen = 0;
    while (wlen < line_fill && line_buf[wlen] != CH_NUL && line_buf[wlen] != CH_COMMA)
      wlen++;
    r.status = STATUS_OK;
    r.mode   = MODE_OFF;
    if (word_equals(wlen, "off", 3)) r.mode = MODE_OFF;
    else if (word_equals(wlen, "normal", 6)) r.mode = MODE_NORMAL;
    else if (word_equals(wlen, "warning", 7)) r.mode = MODE_WARNING;
    else if (word_equals(wlen, "error", 5)) r.mode = MODE_ERROR;
    else r.status = STATUS_ERR;
    return r;
  endfunction

  // Advances the tracker by one byte; returns 1 when the parser ignores the byte.
  function automatic bit track_byte(input logic [7:0] b);
    bit ignored;
    ignored = 1'b0;
    case (frame_phase)
      COLLECTING: begin
        if (b == CH_START) begin
          line_fill = 0;
        end else if (b == CH_CR) begin
          frame_phase = AWAIT_LF;
        end else if (line_fill < LINE_LEN) begin
          line_buf[line_fill] = b;
          line_fill++;
        end else begin
          line_fill   = 0;
          frame_phase = HUNTING;
        end
      end
      AWAIT_LF: begin
        if (b == CH_LF) expected_replies.push_back(judge_command());
        line_fill   = 0;
        frame_phase = HUNTING;
      end
      default: begin
        if (b == CH_START) frame_phase = COLLECTING;
        else ignored = 1'b1;
      end
    endcase
    return ignored;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    if (!track_byte(b)) live_bytes++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_frame(input string body);
    send_byte(CH_START);
    send_text(body);
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  function automatic logic [7:0] rand_line_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == CH_START || b == CH_CR) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic send_line_bytes(input int count);
    for (int i = 0; i < count; i++) send_byte(rand_line_byte());
  endtask

  task automatic test_keywords();
    foreach (kw_names[i]) send_frame(kw_names[i]);
  endtask

  task automatic test_frame_edges();
    // Ignored while hunting, including the extremes of the byte range.
    send_byte(8'hFF);
    send_byte(CH_NUL);
    send_byte(CH_CR);
    send_byte(CH_LF);
    // A second start character empties the line; an LF inside the arguments is data.
    send_byte(CH_START);
    send_text("xx");
    send_byte(CH_START);
    send_text("warning,");
    send_byte(CH_LF);
    send_text("9");
    send_byte(CH_CR);
    send_byte(CH_LF);
    // A zero byte ends the command word.
    send_byte(CH_START);
    send_text("error");
    send_byte(CH_NUL);
    send_text("q");
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_frame("");
    send_frame("war");
    send_frame("errors");
    send_frame(",off");
    // CR without LF drops the frame, and the start character after it is swallowed.
    send_byte(CH_START);
    send_text("off");
    send_byte(CH_CR);
    send_byte(CH_START);
    send_frame("normal");
  endtask

  task automatic test_backpressure();
    hold_request = 400;
    repeat (12) send_frame(kw_names[$urandom_range(0, 3)]);
  endtask

  task automatic send_random_frame();
    int    kind;
    int    pos;
    string word;
    kind = $urandom_range(0, 99);
    word = kw_names[$urandom_range(0, 3)];
    if (kind < 45) begin
      send_byte(CH_START);
      send_text(word);
      if ($urandom_range(0, 1)) begin
        send_byte(CH_COMMA);
        send_line_bytes($urandom_range(0, 10));
      end else if ($urandom_range(0, 3) == 0) begin
        send_byte(CH_NUL);
        send_line_bytes($urandom_range(0, 6));
      end
      send_byte(CH_CR);
      send_byte(CH_LF);
    end else if (kind < 60) begin
      pos = $urandom_range(0, word.len() - 1);
      case ($urandom_range(0, 2))
        0: word = word.substr(0, pos - 1);
        1: word = {word, "s"};
        default: word[pos] = 8'($urandom_range(8'h61, 8'h7A));
      endcase
      send_frame(word);
    end else if (kind < 68) begin
      send_byte(CH_START);
      send_line_bytes($urandom_range(0, 10));
      send_frame(word);
    end else if (kind < 76) begin
      send_byte(CH_START);
      send_text(word);
      send_byte(CH_CR);
      send_byte(($urandom_range(0, 3) == 0) ? CH_START : rand_line_byte() | 8'h80);
    end else if (kind < 84) begin
      // Fill the line to the brim, then overflow, close or restart it.
      send_byte(CH_START);
      send_line_bytes(LINE_LEN);
      case ($urandom_range(0, 2))
        0: begin
          send_line_bytes($urandom_range(1, 6));
          send_byte(CH_CR);
          send_byte(CH_LF);
        end
        1: begin
          send_byte(CH_CR);
          send_byte(CH_LF);
        end
        default: send_frame(word);
      endcase
    end else if (kind < 90) begin
      send_byte(CH_START);
      send_text(word);
      send_byte(CH_COMMA);
      send_line_bytes(LINE_LEN - word.len() - 1);
      send_byte(CH_CR);
      send_byte(CH_LF);
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_traffic();
    live_bytes = 0;
    while (live_bytes < LIVE_TARGET) send_random_frame();
  endtask

  // Receiver: rotates between always ready, random stalls and a fixed pattern, after any requested hold.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      if (sink_left == 0) begin
        sink_mode = $urandom_range(0, 2);
        sink_left = $urandom_range(10, 120);
      end
      sink_left--;
      case (sink_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= (sink_left % 4) != 0;
      endcase
    end
  end

  always @(posedge clk) begin
    cmd_result_t exp;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0b light_mode=%0d",
                                  out_ch.status, out_ch.light_mode));
      end else begin
        exp = expected_replies.pop_front();
        if (out_ch.status !== exp.status)
          report_mismatch($sformatf("status %0b, expected %0b", out_ch.status, exp.status));
        if (out_ch.light_mode !== exp.mode)
          report_mismatch($sformatf("light_mode %0d, expected %0d",
                                    out_ch.light_mode, exp.mode));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_keywords();
    test_frame_edges();
    test_backpressure();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_replies.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_replies.size()));

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
